[design/affine_gap_alignment_scorer_macros.svh]
// Assertion macros shared by the scorer RTL.
`ifndef AFFINE_GAP_ALIGNMENT_SCORER_MACROS_SVH
`define AFFINE_GAP_ALIGNMENT_SCORER_MACROS_SVH
`ifndef SYNTHESIS
`define AGAS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AGAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AGAS_ASSERT_IMPL(label, ante, cons)
`define AGAS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/agas_pkg.sv]
// Types and constants of the affine-gap alignment scorer.
`default_nettype none
package agas_pkg;

  localparam int SYM_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 3;
  localparam int BEST_W  = 16;
  localparam int QEND_W  = 10;
  localparam int TEND_W  = 11;
  localparam int COUNT_W = 20;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_MATCH      = 3'd0,
    REG_MISMATCH   = 3'd1,
    REG_GAP_OPEN   = 3'd2,
    REG_GAP_EXTEND = 3'd3,
    REG_CLIP_START = 3'd4,
    REG_CLIP_END   = 3'd5,
    REG_SEARCH_REV = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_START,
    ST_FILL,
    ST_FINISH,
    ST_DONE
  } state_t;

  // scoring controls handed to the cell
  typedef struct packed {
    logic [CFG_W:0]   open_ext;
    logic [CFG_W-1:0] extend;
    logic             clip_start;
  } cell_cfg_t;

endpackage
`default_nettype wire

[design/agas_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module agas_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/agas_cell.sv]
// One dynamic programming cell: match, vertical and horizontal gap scores.
`default_nettype none
module agas_cell #(
  parameter int SW = 16
) (
  input  wire agas_pkg::cell_cfg_t            cfg,
  input  wire logic signed [agas_pkg::CFG_W-1:0] sub_score,
  input  wire logic signed [SW-1:0]           up_m,
  input  wire logic signed [SW-1:0]           up_v,
  input  wire logic signed [SW-1:0]           left_m,
  input  wire logic signed [SW-1:0]           left_h,
  input  wire logic signed [SW-1:0]           diag_m,
  input  wire logic signed [SW-1:0]           diag_v,
  input  wire logic signed [SW-1:0]           diag_h,
  output logic signed [SW-1:0]                new_m,
  output logic signed [SW-1:0]                new_v,
  output logic signed [SW-1:0]                new_h,
  output logic signed [SW-1:0]                cell_max
);

  localparam int EW = SW + 2;
  localparam logic signed [EW-1:0] EMAX = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = {3'b111, {(SW-1){1'b0}}};

  function automatic logic signed [SW-1:0] sat(input logic signed [EW-1:0] x);
    logic signed [SW-1:0] r;
    if (x > EMAX) r = EMAX[SW-1:0];
    else if (x < EMIN) r = EMIN[SW-1:0];
    else r = x[SW-1:0];
    return r;
  endfunction

  logic signed [EW-1:0] oe_e, ext_e, s_e;
  logic signed [SW-1:0] v_open, v_ext, h_open, h_ext, mx_md, mx, m_sat;

  always_comb begin
    oe_e  = EW'($signed(cfg.open_ext));
    ext_e = EW'($signed(cfg.extend));
    s_e   = EW'(sub_score);
    v_open = sat(EW'(up_m) + oe_e);
    v_ext  = sat(EW'(up_v) + ext_e);
    h_open = sat(EW'(left_m) + oe_e);
    h_ext  = sat(EW'(left_h) + ext_e);
    new_v  = (v_open > v_ext) ? v_open : v_ext;
    new_h  = (h_open > h_ext) ? h_open : h_ext;
    mx_md  = (diag_m > diag_v) ? diag_m : diag_v;
    mx     = (mx_md > diag_h) ? mx_md : diag_h;
    m_sat  = sat(EW'(mx) + s_e);
    new_m  = (cfg.clip_start && m_sat < 0) ? '0 : m_sat;
  end

  logic signed [SW-1:0] c_mv;
  always_comb begin
    c_mv     = (new_m > new_v) ? new_m : new_v;
    cell_max = (c_mv > new_h) ? c_mv : new_h;
  end

endmodule
`default_nettype wire

[design/affine_gap_alignment_scorer.sv]
// Top level of the affine-gap alignment scorer: stores, row memory, sequencer and search.
// A run walks the table one row at a time, one cell per cycle, with a setup state before each
// row. The row memory does a read-modify-write of the previous row. The previous row lives
// in one RAM holding match, vertical and horizontal scores per target column; it needs no
// clearing, as the first row uses the seed values.
// A result waits in an output register; loads are still taken meanwhile, a run is not.
`default_nettype none
`include "affine_gap_alignment_scorer_macros.svh"
module affine_gap_alignment_scorer #(
  parameter int MAX_QUERY   = 512,
  parameter int MAX_TARGET  = 1024,
  parameter int SCORE_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_kind,
  input  wire logic [agas_pkg::SYM_W-1:0]           in_symbol,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [agas_pkg::BEST_W-1:0]        out_best_score,
  output logic signed [agas_pkg::QEND_W-1:0]        out_query_end,
  output logic signed [agas_pkg::TEND_W-1:0]        out_target_end,
  output logic [agas_pkg::COUNT_W-1:0]              out_best_count,
  output logic                                      out_overflow,
  input  wire logic                                 cfg_we,
  input  wire logic [agas_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [agas_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int SW  = SCORE_WIDTH;
  localparam int QAW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int TAW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int QLW = $clog2(MAX_QUERY + 1);
  localparam int TLW = $clog2(MAX_TARGET + 1);
  localparam int HW  = 24;
  localparam int XW  = 34;
  localparam int CW  = agas_pkg::COUNT_W;
  localparam logic signed [SW-1:0] SC_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [XW-1:0] XMAX = (XW'(1) <<< (SW-1)) - XW'(1);
  localparam logic signed [XW-1:0] XMIN = -XMAX - XW'(1);
  localparam logic signed [XW-1:0] B_MAX = XW'(32767);
  localparam logic signed [XW-1:0] B_MIN = -XW'(32768);

  // configuration
  logic signed [7:0] match_r, mismatch_r, open_r, extend_r;
  logic clip_start_r, clip_end_r, search_rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r      <= 8'sd1;
      mismatch_r   <= -8'sd3;
      open_r       <= -8'sd5;
      extend_r     <= -8'sd2;
      clip_start_r <= 1'b1;
      clip_end_r   <= 1'b1;
      search_rev_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agas_pkg::REG_MATCH:      match_r      <= cfg_wdata;
        agas_pkg::REG_MISMATCH:   mismatch_r   <= cfg_wdata;
        agas_pkg::REG_GAP_OPEN:   open_r       <= cfg_wdata;
        agas_pkg::REG_GAP_EXTEND: extend_r     <= cfg_wdata;
        agas_pkg::REG_CLIP_START: clip_start_r <= cfg_wdata[0];
        agas_pkg::REG_CLIP_END:   clip_end_r   <= cfg_wdata[0];
        agas_pkg::REG_SEARCH_REV: search_rev_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  agas_pkg::state_t state_r, state_nxt;
  logic [QLW-1:0] qlen_r;
  logic [TLW-1:0] tlen_r;
  logic           ovf_r;
  logic [QAW-1:0] row_r;
  logic [TAW-1:0] col_r;
  logic           out_valid_r;

  logic accept_in, start_run, last_col, last_row, rd_en, row_we, q_re;
  logic [TAW-1:0] rd_addr;

  assign in_stall  = (state_r != agas_pkg::ST_IDLE) ||
                     (in_kind == agas_pkg::KIND_RUN && out_valid_r);
  assign accept_in = in_valid && !in_stall;
  assign start_run = accept_in && in_kind == agas_pkg::KIND_RUN;
  assign last_col  = TLW'(col_r) == tlen_r - TLW'(1);
  assign last_row  = QLW'(row_r) == qlen_r - QLW'(1);
  assign rd_en     = (state_r == agas_pkg::ST_ROW_START) ||
                     (state_r == agas_pkg::ST_FILL && !last_col);
  assign rd_addr   = (state_r == agas_pkg::ST_ROW_START) ? '0 : col_r + TAW'(1);
  assign row_we    = state_r == agas_pkg::ST_FILL;
  assign q_re      = state_r == agas_pkg::ST_ROW_START;

  // symbol stores
  logic q_we, t_we;
  logic [agas_pkg::SYM_W-1:0] q_sym, t_sym;
  assign q_we = accept_in && in_kind == agas_pkg::KIND_QUERY && qlen_r < QLW'(MAX_QUERY);
  assign t_we = accept_in && in_kind == agas_pkg::KIND_TARGET && tlen_r < TLW'(MAX_TARGET);

  agas_ram #(.DEPTH(MAX_QUERY), .WIDTH(agas_pkg::SYM_W), .AW(QAW)) u_query (
    .clk, .we(q_we), .waddr(qlen_r[QAW-1:0]), .wdata(in_symbol),
    .re(q_re), .raddr(row_r), .rdata(q_sym)
  );

  agas_ram #(.DEPTH(MAX_TARGET), .WIDTH(agas_pkg::SYM_W), .AW(TAW)) u_target (
    .clk, .we(t_we), .waddr(tlen_r[TAW-1:0]), .wdata(in_symbol),
    .re(rd_en), .raddr(rd_addr), .rdata(t_sym)
  );

  // previous row: {match, vgap, hgap} per target column
  logic [3*SW-1:0] row_rdata, row_wdata;
  agas_ram #(.DEPTH(MAX_TARGET), .WIDTH(3*SW), .AW(TAW)) u_row (
    .clk, .we(row_we), .waddr(col_r), .wdata(row_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(row_rdata)
  );

  // cell datapath
  logic signed [SW-1:0] up_m, up_v, up_h, new_m, new_v, new_h, cell_max;
  logic signed [SW-1:0] left_m_r, left_h_r, diag_m_r, diag_v_r, diag_h_r;
  logic signed [SW-1:0] c0m_r, c0h_r, c0m_nxt, c0h_nxt;
  logic signed [HW-1:0] hacc_r;
  logic signed [XW-1:0] hsum;
  logic signed [7:0]    sub_score;
  agas_pkg::cell_cfg_t  ccfg;

  always_comb begin
    if (row_r == '0) begin
      up_m = '0;
      up_v = SC_MIN;
      up_h = SC_MIN;
    end else begin
      up_m = row_rdata[3*SW-1:2*SW];
      up_v = row_rdata[2*SW-1:SW];
      up_h = row_rdata[SW-1:0];
    end
    sub_score       = (q_sym == t_sym) ? match_r : mismatch_r;
    ccfg.open_ext   = 9'(open_r) + 9'(extend_r);
    ccfg.extend     = extend_r;
    ccfg.clip_start = clip_start_r;
    hsum = XW'(hacc_r) + XW'(extend_r);
    c0m_nxt = clip_start_r ? '0 : SC_MIN;
    if (clip_start_r) c0h_nxt = SC_MIN;
    else if (hsum > XMAX) c0h_nxt = XMAX[SW-1:0];
    else if (hsum < XMIN) c0h_nxt = XMIN[SW-1:0];
    else c0h_nxt = hsum[SW-1:0];
    row_wdata = {new_m, new_v, new_h};
  end

  agas_cell #(.SW(SW)) u_cell (
    .cfg(ccfg), .sub_score,
    .up_m, .up_v, .left_m(left_m_r), .left_h(left_h_r),
    .diag_m(diag_m_r), .diag_v(diag_v_r), .diag_h(diag_h_r),
    .new_m, .new_v, .new_h, .cell_max
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= agas_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      agas_pkg::ST_IDLE: begin
        if (start_run) begin
          state_nxt = (qlen_r == '0 || tlen_r == '0) ? agas_pkg::ST_DONE
                                                      : agas_pkg::ST_ROW_START;
        end
      end
      agas_pkg::ST_ROW_START: state_nxt = agas_pkg::ST_FILL;
      agas_pkg::ST_FILL: begin
        if (last_col) state_nxt = last_row ? agas_pkg::ST_FINISH : agas_pkg::ST_ROW_START;
      end
      agas_pkg::ST_FINISH: state_nxt = agas_pkg::ST_DONE;
      agas_pkg::ST_DONE:   state_nxt = agas_pkg::ST_IDLE;
      default:             state_nxt = agas_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= '0;
      tlen_r <= '0;
      ovf_r  <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      if (q_we) qlen_r <= qlen_r + QLW'(1);
      if (t_we) tlen_r <= tlen_r + TLW'(1);
      if (accept_in && ((in_kind == agas_pkg::KIND_QUERY && !q_we) ||
                        (in_kind == agas_pkg::KIND_TARGET && !t_we))) begin
        ovf_r <= 1'b1;
      end
      if (start_run) row_r <= '0;
      if (state_r == agas_pkg::ST_ROW_START) col_r <= '0;
      if (state_r == agas_pkg::ST_FILL) begin
        if (last_col) row_r <= row_r + QAW'(1);
        else col_r <= col_r + TAW'(1);
      end
      if (state_r == agas_pkg::ST_DONE) begin
        qlen_r <= '0;
        tlen_r <= '0;
        ovf_r  <= 1'b0;
      end
    end
  end

  // column zero and the running cell registers
  always_ff @(posedge clk) begin
    if (start_run) begin
      c0m_r  <= '0;
      c0h_r  <= SC_MIN;
      hacc_r <= HW'(open_r);
    end
    if (state_r == agas_pkg::ST_ROW_START) begin
      diag_m_r <= c0m_r;
      diag_v_r <= SC_MIN;
      diag_h_r <= c0h_r;
      left_m_r <= c0m_nxt;
      left_h_r <= c0h_nxt;
      c0m_r    <= c0m_nxt;
      c0h_r    <= c0h_nxt;
      hacc_r   <= hsum[HW-1:0];
    end
    if (state_r == agas_pkg::ST_FILL) begin
      diag_m_r <= up_m;
      diag_v_r <= up_v;
      diag_h_r <= up_h;
      left_m_r <= new_m;
      left_h_r <= new_h;
    end
  end

  // best-cell search, one stage behind the cell
  logic                 s_valid_r;
  logic signed [SW-1:0] s_c_r, best_r;
  logic [QAW-1:0]       s_q_r, fq_r, lq_r;
  logic [TAW-1:0]       s_t_r, ft_r, lt_r;
  logic                 any_r;
  logic [CW-1:0]        count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= state_r == agas_pkg::ST_FILL && (clip_end_r || last_row);
    end
  end

  always_ff @(posedge clk) begin
    s_c_r <= cell_max;
    s_q_r <= row_r;
    s_t_r <= col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start_run) begin
      any_r   <= 1'b0;
      best_r  <= SC_MIN;
      count_r <= '0;
    end else if (s_valid_r) begin
      priority if (!any_r || s_c_r > best_r) begin
        any_r   <= 1'b1;
        best_r  <= s_c_r;
        count_r <= CW'(1);
        fq_r    <= s_q_r;
        lq_r    <= s_q_r;
        ft_r    <= s_t_r;
        lt_r    <= s_t_r;
      end else if (s_c_r == best_r) begin
        if (count_r != {CW{1'b1}}) count_r <= count_r + CW'(1);
        lq_r <= s_q_r;
        lt_r <= s_t_r;
      end
    end
  end

  // result register
  logic signed [XW-1:0] best_e, rq_e, rt_e;
  always_comb begin
    best_e = XW'(best_r);
    if (best_e > B_MAX) best_e = B_MAX;
    else if (best_e < B_MIN) best_e = B_MIN;
    rq_e = any_r ? XW'(search_rev_r ? lq_r : fq_r) : -XW'(1);
    rt_e = any_r ? XW'(search_rev_r ? lt_r : ft_r) : -XW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == agas_pkg::ST_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == agas_pkg::ST_DONE) begin
      out_best_score <= best_e[agas_pkg::BEST_W-1:0];
      out_query_end  <= rq_e[agas_pkg::QEND_W-1:0];
      out_target_end <= rt_e[agas_pkg::TEND_W-1:0];
      out_best_count <= count_r;
      out_overflow   <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

  `AGAS_ASSERT_IMPL(a_fill_stalls, state_r == agas_pkg::ST_FILL, in_stall)
  `AGAS_ASSERT_NEXT(a_done_presents, state_r == agas_pkg::ST_DONE, out_valid_r)
  `AGAS_ASSERT_IMPL(a_rmw_addr, state_r == agas_pkg::ST_FILL, col_r == $past(rd_addr))
  `AGAS_ASSERT_IMPL(a_none_no_count, any_r == 1'b0, count_r == '0)

endmodule
`default_nettype wire

[test/tb_affine_gap_alignment_scorer.sv]
// Self-checking testbench for the affine-gap alignment scorer.
`default_nettype none
module tb_affine_gap_alignment_scorer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SC_MAX = 32767;
  localparam longint SC_MIN = -32768;
  localparam int     QCAP   = 512;
  localparam int     TCAP   = 1024;
  localparam int     LIMIT  = 2000000;
  localparam int     SYMW   = agas_pkg::SYM_W;
  localparam int     CFGW   = agas_pkg::CFG_W;
  localparam int     CIW    = agas_pkg::CIDX_W;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [agas_pkg::BEST_W-1:0] best;
    logic signed [agas_pkg::QEND_W-1:0] qend;
    logic signed [agas_pkg::TEND_W-1:0] tend;
    logic [agas_pkg::COUNT_W-1:0]       cnt;
    logic                               ovf;
  } score_res_t;

  class align_scoreboard;
    int            match_sc, mismatch_sc, open_sc, extend_sc;
    bit            clip_start, clip_end, reverse;
    byte unsigned  qsym[QCAP];
    byte unsigned  tsym[TCAP];
    int            qlen, tlen;
    bit            ovf;
    longint        mrow[TCAP+1], vrow[TCAP+1], hrow[TCAP+1];
    score_res_t    pending_scores[$];
    int            errors;

    function new();
      match_sc = 1; mismatch_sc = -3; open_sc = -5; extend_sc = -2;
      clip_start = 1; clip_end = 1; reverse = 0;
      qlen = 0; tlen = 0; ovf = 0; errors = 0;
    endfunction

    function void set_reg(agas_pkg::reg_idx_t idx, logic [CFGW-1:0] v);
      case (idx)
        agas_pkg::REG_MATCH:      match_sc = $signed(v);
        agas_pkg::REG_MISMATCH:   mismatch_sc = $signed(v);
        agas_pkg::REG_GAP_OPEN:   open_sc = $signed(v);
        agas_pkg::REG_GAP_EXTEND: extend_sc = $signed(v);
        agas_pkg::REG_CLIP_START: clip_start = v[0];
        agas_pkg::REG_CLIP_END:   clip_end = v[0];
        agas_pkg::REG_SEARCH_REV: reverse = v[0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > SC_MAX) return SC_MAX;
      if (v < SC_MIN) return SC_MIN;
      return v;
    endfunction

    function longint mx(longint a, longint b);
      return a > b ? a : b;
    endfunction

    function void score_table();
      longint     oe, best, dm, dv, dh, nv, nh, nm, c;
      int         first_row, count, fq, ft, lq, lt;
      bit         any;
      score_res_t r;
      oe = open_sc + extend_sc;
      best = SC_MIN; count = 0; any = 0;
      fq = -1; ft = -1; lq = -1; lt = -1;
      for (int j = 0; j <= tlen; j++) begin
        mrow[j] = 0; vrow[j] = SC_MIN; hrow[j] = SC_MIN;
      end
      first_row = clip_end ? 1 : qlen;
      for (int i = 1; i <= qlen; i++) begin
        dm = mrow[0]; dv = vrow[0]; dh = hrow[0];
        vrow[0] = SC_MIN;
        if (clip_start) begin
          mrow[0] = 0; hrow[0] = SC_MIN;
        end else begin
          mrow[0] = SC_MIN; hrow[0] = sat(open_sc + longint'(extend_sc) * i);
        end
        for (int j = 1; j <= tlen; j++) begin
          nv = mx(sat(mrow[j] + oe), sat(vrow[j] + extend_sc));
          nh = mx(sat(mrow[j-1] + oe), sat(hrow[j-1] + extend_sc));
          nm = sat(mx(mx(dm, dv), dh) +
                   ((qsym[i-1] == tsym[j-1]) ? match_sc : mismatch_sc));
          if (clip_start && nm < 0) nm = 0;
          dm = mrow[j]; dv = vrow[j]; dh = hrow[j];
          mrow[j] = nm; vrow[j] = nv; hrow[j] = nh;
          if (i >= first_row) begin
            c = mx(mx(nm, nv), nh);
            if (!any || c > best) begin
              any = 1; best = c; count = 1;
              fq = i - 1; lq = i - 1; ft = j - 1; lt = j - 1;
            end else if (c == best) begin
              if (count < (1 << agas_pkg::COUNT_W) - 1) count++;
              lq = i - 1; lt = j - 1;
            end
          end
        end
      end
      r.best = best;
      r.qend = reverse ? lq : fq;
      r.tend = reverse ? lt : ft;
      r.cnt  = count;
      r.ovf  = ovf;
      pending_scores.push_back(r);
      qlen = 0; tlen = 0; ovf = 0;
    endfunction

    // called for every accepted input transfer
    function void note_item(logic [1:0] kind, logic [SYMW-1:0] sym);
      case (kind)
        agas_pkg::KIND_QUERY: begin
          if (qlen < QCAP) qsym[qlen++] = sym;
          else ovf = 1;
        end
        agas_pkg::KIND_TARGET: begin
          if (tlen < TCAP) tsym[tlen++] = sym;
          else ovf = 1;
        end
        agas_pkg::KIND_RUN: score_table();
        default: ;
      endcase
    endfunction

    function void check_result(score_res_t act);
      score_res_t exp_r;
      if (pending_scores.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", act);
        return;
      end
      exp_r = pending_scores.pop_front();
      if (exp_r.best !== act.best || exp_r.qend !== act.qend ||
          exp_r.tend !== act.tend || exp_r.cnt !== act.cnt || exp_r.ovf !== act.ovf) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp best %0d q %0d t %0d n %0d ovf %0d / got %0d %0d %0d %0d %0d",
                   exp_r.best, exp_r.qend, exp_r.tend, exp_r.cnt, exp_r.ovf,
                   act.best, act.qend, act.tend, act.cnt, act.ovf);
      end
    endfunction

    function int pending();
      return pending_scores.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [SYMW-1:0] in_symbol = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [agas_pkg::BEST_W-1:0] out_best_score;
  logic signed [agas_pkg::QEND_W-1:0] out_query_end;
  logic signed [agas_pkg::TEND_W-1:0] out_target_end;
  logic [agas_pkg::COUNT_W-1:0] out_best_count;
  logic out_overflow;
  logic cfg_we = 0;
  logic [CIW-1:0] cfg_index = '0;
  logic [CFGW-1:0] cfg_wdata = '0;

  align_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  affine_gap_alignment_scorer dut (.*);

  always #4 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_best_score, out_query_end, out_target_end,
                       out_best_count, out_overflow});

  task automatic send_item(logic [1:0] kind, logic [SYMW-1:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid  <= 1;
    in_kind   <= kind;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, sym);
    @(negedge clk);
  endtask

  // idle point: everything delivered, then the block is left to settle
  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_regs(logic [CFGW-1:0] m, logic [CFGW-1:0] mm, logic [CFGW-1:0] go,
                            logic [CFGW-1:0] ge, bit cs, bit ce, bit rv);
    logic [CFGW-1:0] vals[7];
    vals = '{m, mm, go, ge, {7'd0, cs}, {7'd0, ce}, {7'd0, rv}};
    for (int k = 0; k < 7; k++) begin
      cfg_we    <= 1;
      cfg_index <= CIW'(k);
      cfg_wdata <= vals[k];
      sb.set_reg(agas_pkg::reg_idx_t'(k), vals[k]);
      @(negedge clk);
    end
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic [SYMW-1:0] pick_sym();
    return ($urandom_range(3) == 0) ? SYMW'($urandom_range(255)) : SYMW'($urandom_range(3));
  endfunction

  // random query/target pair with a little noise, then a run
  task automatic random_alignment();
    int qn, tn, qc, tc;
    qn = $urandom_range(5) == 0 ? 0 : $urandom_range(1, 12);
    tn = $urandom_range(5) == 0 ? 0 : $urandom_range(1, 12);
    qc = 0; tc = 0;
    while (qc < qn || tc < tn) begin
      if ($urandom_range(29) == 0) send_item(KIND_UNUSED, pick_sym());
      if (tc >= tn || (qc < qn && $urandom_range(1))) begin
        send_item(agas_pkg::KIND_QUERY, pick_sym()); qc++;
      end else begin
        send_item(agas_pkg::KIND_TARGET, pick_sym()); tc++;
      end
    end
    send_item(agas_pkg::KIND_RUN, SYMW'($urandom_range(255)));
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty sequences, one cell, byte extremes, unused kind
    send_item(agas_pkg::KIND_RUN, 8'h00);
    send_item(agas_pkg::KIND_QUERY, 8'h00);
    send_item(agas_pkg::KIND_RUN, 8'hFF);
    send_item(agas_pkg::KIND_TARGET, 8'hFF);
    send_item(agas_pkg::KIND_RUN, 8'h00);
    send_item(agas_pkg::KIND_QUERY, 8'hFF);
    send_item(agas_pkg::KIND_TARGET, 8'hFF);
    send_item(agas_pkg::KIND_RUN, 8'h00);
    send_item(KIND_UNUSED, 8'hAA);
    send_item(agas_pkg::KIND_QUERY, 8'h55);
    send_item(KIND_UNUSED, 8'h55);
    send_item(agas_pkg::KIND_TARGET, 8'h00);
    send_item(agas_pkg::KIND_TARGET, 8'h55);
    send_item(agas_pkg::KIND_QUERY, 8'h00);
    send_item(agas_pkg::KIND_RUN, 8'h00);

    // capacity: one load past each store's end; anchored start with the
    // harshest gaps so the seeded column saturates over the deep rows
    drain();
    write_regs(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 0, 1, 0);
    for (int k = 0; k <= QCAP; k++) send_item(agas_pkg::KIND_QUERY, pick_sym());
    send_item(agas_pkg::KIND_TARGET, 8'h01);
    send_item(agas_pkg::KIND_TARGET, 8'h02);
    send_item(agas_pkg::KIND_RUN, 8'h00);
    send_item(agas_pkg::KIND_QUERY, 8'h01);
    for (int k = 0; k <= TCAP; k++) send_item(agas_pkg::KIND_TARGET, pick_sym());
    send_item(agas_pkg::KIND_RUN, 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      send_idle_pct  = (ph < 2) ? 6 : (ph < 4) ? 56 : 0;
      recv_stall_pct = (ph < 2) ? 56 : (ph < 4) ? 6 : 0;
      case (ph)
        0: write_regs(8'sd127, 8'sd127, 8'sd127, 8'sd127, 1, 1, 1);
        1: write_regs(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 0, 0, 0);
        default: write_regs(CFGW'($urandom_range(255)), CFGW'($urandom_range(255)),
                            CFGW'($urandom_range(255)), CFGW'($urandom_range(255)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
      endcase
      for (int n = 0; n < 4; n++) begin
        if (ph == 3 && n == 2) begin
          in_valid <= 0;
          while (sb.pending() != 0) @(negedge clk);
        end
        random_alignment();
      end
    end

    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
